[rtl/sha256_stream_hasher_top_assert.svh]
// Assertion macros for the SHA-256 stream hasher checker.
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/sha_pkg.sv]
// Package: SHA-256 constants, types and round functions.
package sha_pkg;
  localparam int QueueDepth = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } sha_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROUND, ST_ADD, ST_PAD, ST_EMIT
  } sha_state_t;

  typedef logic [7:0][31:0] sha_words_t;

  localparam sha_words_t IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

[rtl/sha_stream_if.sv]
// Interface: valid/ready channel with a typed payload.
interface sha_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/sha_front.sv]
// Front end: input queue between the port and the compression engine.
module sha_front
  import sha_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  logic    clk,
  input  logic    rst,
  sha_stream_if.sink in_ch,
  output logic    q_valid,
  output sha_in_t q_item,
  input  logic    q_take
);
  localparam int AW = $clog2(Depth);
  sha_in_t mem [Depth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic push, pop;

  assign in_ch.ready = (count != (AW+1)'(Depth));
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (count != '0);
  assign pop = q_take && q_valid;
  assign q_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_ch.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

[rtl/sha_back.sv]
// Back end: block buffer, 64-round compression, padding and digest output.
module sha_back
  import sha_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  sha_in_t q_item,
  output logic    q_take,
  sha_stream_if.source out_ch
);
  sha_state_t state, state_next;
  logic [15:0][31:0] w;
  logic [5:0]  fill;
  logic [63:0] bitcnt;
  sha_words_t  h, v;
  logic [5:0]  rnd;
  logic        final_blk;
  logic        pad_second;
  logic        pad_zero;
  logic [2:0]  widx;

  // Byte insertion into the 16-word window.
  logic [3:0]  wsel;
  logic [1:0]  bsel;
  assign wsel = fill[5:2];
  assign bsel = fill[1:0];

  logic [31:0] s0, s1, wnew, t1, t2, sum0, sum1, ch, mj;
  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wnew = s1 + w[9] + s0 + w[0];
    sum1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + sum1 + ch + round_k(rnd) + w[0];
    sum0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = sum0 + mj;
  end

  always_comb begin
    state_next = state;
    q_take = 1'b0;
    case (state)
      ST_IDLE: begin
        q_take = q_valid;
        if (q_valid) begin
          if (q_item.byte_present && fill == 6'd63) state_next = ST_ROUND;
          else if (q_item.end_of_message) state_next = ST_PAD;
        end
      end
      ST_ROUND: if (rnd == 6'd63) state_next = ST_ADD;
      ST_ADD: begin
        if (final_blk) state_next = ST_EMIT;
        else if (pad_second || pad_zero) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_PAD: state_next = ST_ROUND;
      ST_EMIT: if (out_ch.ready && widx == 3'd7) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_ch.valid = (state == ST_EMIT);
  assign out_ch.payload = '{digest_word: h[widx], word_number: widx,
                            last_word: (widx == 3'd7)};

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0; bitcnt <= '0; h <= IV; rnd <= '0;
      final_blk <= 1'b0; pad_second <= 1'b0; pad_zero <= 1'b0; widx <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_item.byte_present) begin
              w[wsel][8*(3-bsel) +: 8] <= q_item.data_byte;
              fill <= fill + 1'b1;
              bitcnt <= bitcnt + 64'd8;
            end
            pad_second <= q_item.end_of_message;
            if (q_item.byte_present && fill == 6'd63) begin
              v <= h; rnd <= '0; final_blk <= 1'b0;
            end
          end
        end
        ST_PAD: begin
          // Pad: 0x80 at fill (unless already placed), zeros, length.
          for (int i = 0; i < 64; i++) begin
            if (pad_second && 6'(i) == fill) w[i/4][8*(3-i%4) +: 8] <= 8'h80;
            else if (!pad_second || 6'(i) > fill) w[i/4][8*(3-i%4) +: 8] <= 8'h00;
            else if (6'(i) < fill) w[i/4][8*(3-i%4) +: 8] <= w[i/4][8*(3-i%4) +: 8];
          end
          if (!pad_second || fill < 6'd56) begin
            final_blk <= 1'b1;
            pad_zero <= 1'b0;
            w[14] <= bitcnt[63:32];
            w[15] <= bitcnt[31:0];
          end else begin
            // No room for the length: follow with an all-zero length block.
            final_blk <= 1'b0;
            pad_zero <= 1'b1;
          end
          pad_second <= 1'b0;
          v <= h; rnd <= '0;
        end
        ST_ROUND: begin
          w <= {wnew, w[15:1]};
          v <= {v[6:4], v[3] + t1, v[2:0], t1 + t2};
          rnd <= rnd + 1'b1;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          fill <= '0;
        end
        ST_EMIT: begin
          if (out_ch.ready) begin
            widx <= widx + 1'b1;
            if (widx == 3'd7) begin
              h <= IV; fill <= '0; bitcnt <= '0; final_blk <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

[rtl/sha256_stream_hasher_top.sv]
// Top level: SHA-256 stream hasher, byte items in, eight digest-word items out.
// Items enter a four-entry queue and are absorbed by the back end one per
// cycle while it is idle; the 64th byte of a block starts the shared round
// unit, which runs the 64 rounds in turn, and an add step then folds the
// working words into the chaining words; the queue takes arriving bytes
// meanwhile until it is full. An end-of-message item adds one or two padded
// compressions, then the eight digest words leave at one per cycle that the
// sink is ready. Digest words follow H0 first; chaining words reload
// afterwards.
module sha256_stream_hasher_top
  import sha_pkg::*;
#(
  parameter int QDepth = QueueDepth
) (
  input logic clk,
  input logic rst,
  sha_stream_if.sink   in_ch,
  sha_stream_if.source out_ch
);
  logic    q_valid, q_take;
  sha_in_t q_item;

  // Hold arriving items in the queue until the back end is free.
  sha_front #(.Depth(QDepth)) u_front (
    .clk, .rst, .in_ch, .q_valid, .q_item, .q_take);

  // Absorb, compress, pad and emit.
  sha_back u_back (.clk, .rst, .q_valid, .q_item, .q_take, .out_ch);
endmodule

[rtl/sha_checker.sv]
// Checker: port-level assertions for the SHA-256 stream hasher.
`include "sha256_stream_hasher_top_assert.svh"
module sha_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  word_number,
  input logic        last_word,
  input logic [31:0] digest_word
);
  `SHA_ASSERT_IMP(a_last, clk, rst, out_valid, last_word == (word_number == 3'd7))
  `SHA_ASSERT_NEXT(a_adv, clk, rst, out_valid && out_ready && !last_word, out_valid && word_number == $past(word_number) + 3'd1)
  `SHA_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(digest_word))
endmodule

bind sha256_stream_hasher_top sha_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .word_number(out_ch.payload.word_number), .last_word(out_ch.payload.last_word),
  .digest_word(out_ch.payload.digest_word));
